[rtl/greedy_graph_coloring_assert.svh]
// ---------------------------------------------------------------------------
// Greedy graph coloring assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef GREEDY_GRAPH_COLORING_ASSERT_SVH
`define GREEDY_GRAPH_COLORING_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define GCOL_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("greedy graph coloring check failed");

// Next-cycle implication, disabled while rst is high.
`define GCOL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("greedy graph coloring check failed");

`endif

[rtl/gcol_pkg.sv]
// ---------------------------------------------------------------------------
// Greedy graph coloring package
// Sizes, codes, types and helper functions shared by the coloring engine.
// ---------------------------------------------------------------------------
package gcol_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_DEGREE   = 8;

   localparam int ACTION_W = 2;
   localparam int VERTEX_W = 10;
   localparam int SLOT_W   = 3;
   localparam int DEGREE_W = 4;
   localparam int COLOR_W  = 4;

   localparam int VTX_AW     = $clog2(MAX_VERTICES);
   localparam int SLOT_AW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int NBR_AW     = VTX_AW + SLOT_AW;
   localparam int NBR_DEPTH  = MAX_VERTICES << SLOT_AW;
   localparam int NUM_COLORS = MAX_DEGREE + 1;
   localparam int SCAN_W     = $clog2(MAX_DEGREE + 2);
   localparam int COLOR_MAX  = (1 << COLOR_W) - 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_COLOR = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_DEGREE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                nbr_we;
      logic [NBR_AW-1:0]   nbr_waddr;
      logic [VERTEX_W-1:0] nbr_wdata;
      logic [NBR_AW-1:0]   nbr_raddr;
      logic                deg_we;
      logic [VTX_AW-1:0]   deg_waddr;
      logic [DEGREE_W-1:0] deg_wdata;
      logic [VTX_AW-1:0]   deg_raddr;
      logic                col_we;
      logic [VTX_AW-1:0]   col_waddr;
      logic [COLOR_W-1:0]  col_wdata;
      logic [VTX_AW-1:0]   col_raddr;
   } tbl_req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] nbr_rdata;
      logic [DEGREE_W-1:0] deg_rdata;
      logic [COLOR_W-1:0]  col_rdata;
   } tbl_rsp_type;

   typedef struct packed {
      logic               clear;
      logic               mark;
      logic [COLOR_W-1:0] color;
   } pick_ctl_type;

   function automatic logic vertex_ok(input logic [VERTEX_W-1:0] v);
      return 32'(v) < MAX_VERTICES;
   endfunction

   function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
      return 32'(s) < MAX_DEGREE;
   endfunction

   function automatic logic [DEGREE_W-1:0] clamp_degree(input logic [DEGREE_W-1:0] d);
      return (32'(d) > MAX_DEGREE) ? DEGREE_W'(MAX_DEGREE) : d;
   endfunction

   // Smallest color whose bit is clear; bit i of used stands for color i+1.
   function automatic logic [COLOR_W-1:0] first_free(input logic [NUM_COLORS-1:0] used);
      int c;
      c = NUM_COLORS + 1;
      for (int i = NUM_COLORS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            c = i + 1;
         end
      end
      if (c > COLOR_MAX) begin
         c = COLOR_MAX;
      end
      return COLOR_W'(c);
   endfunction

endpackage

[rtl/gcol_if.sv]
// ---------------------------------------------------------------------------
// Greedy graph coloring channels
// Valid/ready channels for request words and response words.
// ---------------------------------------------------------------------------
interface gcol_req_if
   import gcol_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VERTEX_W-1:0] vertex;
   logic [SLOT_W-1:0]   slot;
   logic [VERTEX_W-1:0] neighbor;
   logic [DEGREE_W-1:0] degree;

   modport source (output valid, output action, output vertex, output slot,
                   output neighbor, output degree, input ready);
   modport sink   (input valid, input action, input vertex, input slot,
                   input neighbor, input degree, output ready);
endinterface

interface gcol_rsp_if
   import gcol_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color;
   logic [COLOR_W-1:0] max_color;

   modport source (output valid, output color, output max_color, input ready);
   modport sink   (input valid, input color, input max_color, output ready);
endinterface

[rtl/greedy_graph_coloring.sv]
// ---------------------------------------------------------------------------
// Greedy graph coloring engine
// First-fit coloring of a bounded-degree graph held in on-chip tables.
//
// req_ch carries request words: a load writes one neighbor slot and the
// degree of a vertex and is taken one per cycle; a clear wipes all colors
// and the running maximum; a color request names the next vertex to color.
// rsp_ch returns one word per color request with a vertex in range: the
// chosen color and the largest color handed out since the last clear.
// A color request keeps the block busy: one degree read, then the
// neighbor table and color table are walked one slot per cycle through a
// two-deep read pipeline, and a final state picks the color. The response
// appears the cycle after the pick and req_ch is ready again.
// A clear sweeps every entry of the color table. After reset the degree
// and color tables are swept with req_ch not ready. A response waiting
// on rsp_ch does not block new requests; only the pick of the next color
// waits for it.
// ---------------------------------------------------------------------------
module greedy_graph_coloring
   import gcol_pkg::*;
(
   input logic       clock,
   input logic       reset,
   gcol_req_if.sink  req_ch,
   gcol_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;

   logic [VTX_AW-1:0]   sweep_ff, sweep_in;
   logic [VTX_AW-1:0]   vertex_ff, vertex_in;
   logic [DEGREE_W-1:0] deg_ff, deg_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic                nbr_vld_ff, nbr_vld_in;
   logic                col_vld_ff, col_vld_in;
   logic [COLOR_W-1:0]  max_ff, max_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [COLOR_W-1:0]  rsp_max_ff, rsp_max_in;

   tbl_req_type        tbl_req;
   tbl_rsp_type        tbl_rsp;
   pick_ctl_type       pick_ctl;
   logic [COLOR_W-1:0] free_color;
   logic [COLOR_W-1:0] new_max;

   logic req_accept;
   logic out_free;
   logic sweep_last;
   logic scan_done;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign sweep_last = 32'(sweep_ff) == MAX_VERTICES - 1;
   // The last neighbor color lands in the picker in the cycle scan reaches degree + 1.
   assign scan_done  = 32'(scan_ff) == 32'(deg_ff) + 1;
   assign new_max    = (free_color > max_ff) ? free_color : max_ff;

   gcol_tables u_tables (
      .clock   (clock),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   gcol_pick u_pick (
      .clock      (clock),
      .pick_ctl   (pick_ctl),
      .free_color (free_color)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.action)
                  ACT_CLEAR: state_in = ST_SWEEP;
                  ACT_COLOR: begin
                     if (vertex_ok(req_ch.vertex)) begin
                        state_in = ST_DEGREE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEGREE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);

      tbl_req           = '0;
      tbl_req.nbr_raddr = {vertex_ff, scan_ff[SLOT_AW-1:0]};
      tbl_req.deg_raddr = req_ch.vertex[VTX_AW-1:0];
      tbl_req.col_raddr = tbl_rsp.nbr_rdata[VTX_AW-1:0];

      pick_ctl       = '0;
      pick_ctl.mark  = col_vld_ff;
      pick_ctl.color = tbl_rsp.col_rdata;

      sweep_in     = sweep_ff;
      vertex_in    = vertex_ff;
      deg_in       = deg_ff;
      scan_in      = scan_ff;
      max_in       = max_ff;
      nbr_vld_in   = (state_ff == ST_SCAN) && (32'(scan_ff) < 32'(deg_ff));
      col_vld_in   = nbr_vld_ff && vertex_ok(tbl_rsp.nbr_rdata);
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_color_in = rsp_color_ff;
      rsp_max_in   = rsp_max_ff;

      case (state_ff)
         ST_INIT, ST_SWEEP: begin
            tbl_req.col_we    = 1'b1;
            tbl_req.col_waddr = sweep_ff;
            tbl_req.col_wdata = '0;
            if (state_ff == ST_INIT) begin
               tbl_req.deg_we    = 1'b1;
               tbl_req.deg_waddr = sweep_ff;
               tbl_req.deg_wdata = '0;
            end
            sweep_in = sweep_last ? '0 : sweep_ff + VTX_AW'(1);
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.action)
                  ACT_LOAD: begin
                     if (vertex_ok(req_ch.vertex) && slot_ok(req_ch.slot)) begin
                        tbl_req.nbr_we    = 1'b1;
                        tbl_req.nbr_waddr = {req_ch.vertex[VTX_AW-1:0],
                                             req_ch.slot[SLOT_AW-1:0]};
                        tbl_req.nbr_wdata = req_ch.neighbor;
                        tbl_req.deg_we    = 1'b1;
                        tbl_req.deg_waddr = req_ch.vertex[VTX_AW-1:0];
                        tbl_req.deg_wdata = clamp_degree(req_ch.degree);
                     end
                  end
                  ACT_CLEAR: begin
                     max_in   = '0;
                     sweep_in = '0;
                  end
                  ACT_COLOR: begin
                     vertex_in      = req_ch.vertex[VTX_AW-1:0];
                     pick_ctl.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEGREE: begin
            deg_in  = tbl_rsp.deg_rdata;
            scan_in = '0;
         end
         ST_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
         end
         ST_FINISH: begin
            if (out_free) begin
               tbl_req.col_we    = 1'b1;
               tbl_req.col_waddr = vertex_ff;
               tbl_req.col_wdata = free_color;
               max_in            = new_max;
               rsp_valid_in      = 1'b1;
               rsp_color_in      = free_color;
               rsp_max_in        = new_max;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         max_ff       <= '0;
         nbr_vld_ff   <= 1'b0;
         col_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         max_ff       <= max_in;
         nbr_vld_ff   <= nbr_vld_in;
         col_vld_ff   <= col_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vertex_ff    <= vertex_in;
      deg_ff       <= deg_in;
      scan_ff      <= scan_in;
      rsp_color_ff <= rsp_color_in;
      rsp_max_ff   <= rsp_max_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.color     = rsp_color_ff;
   assign rsp_ch.max_color = rsp_max_ff;

endmodule

[rtl/gcol_tables.sv]
// ---------------------------------------------------------------------------
// Greedy graph coloring tables
// Neighbor, degree and color memories with registered read data.
// ---------------------------------------------------------------------------
module gcol_tables
   import gcol_pkg::*;
(
   input  logic        clock,
   input  tbl_req_type tbl_req,
   output tbl_rsp_type tbl_rsp
);

   logic [VERTEX_W-1:0] nbr_mem [NBR_DEPTH];
   logic [DEGREE_W-1:0] deg_mem [MAX_VERTICES];
   logic [COLOR_W-1:0]  col_mem [MAX_VERTICES];

   logic [VERTEX_W-1:0] nbr_rdata_ff;
   logic [DEGREE_W-1:0] deg_rdata_ff;
   logic [COLOR_W-1:0]  col_rdata_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.nbr_we) begin
         nbr_mem[tbl_req.nbr_waddr] <= tbl_req.nbr_wdata;
      end
      nbr_rdata_ff <= nbr_mem[tbl_req.nbr_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_req.deg_we) begin
         deg_mem[tbl_req.deg_waddr] <= tbl_req.deg_wdata;
      end
      deg_rdata_ff <= deg_mem[tbl_req.deg_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_req.col_we) begin
         col_mem[tbl_req.col_waddr] <= tbl_req.col_wdata;
      end
      col_rdata_ff <= col_mem[tbl_req.col_raddr];
   end

   assign tbl_rsp.nbr_rdata = nbr_rdata_ff;
   assign tbl_rsp.deg_rdata = deg_rdata_ff;
   assign tbl_rsp.col_rdata = col_rdata_ff;

endmodule

[rtl/gcol_pick.sv]
// ---------------------------------------------------------------------------
// Greedy graph coloring color picker
// Collects the colors seen on the neighbors and finds the first free one.
// ---------------------------------------------------------------------------
module gcol_pick
   import gcol_pkg::*;
(
   input  logic               clock,
   input  pick_ctl_type       pick_ctl,
   output logic [COLOR_W-1:0] free_color
);

   logic [NUM_COLORS-1:0] used_ff;
   logic [NUM_COLORS-1:0] used_in;

   always_comb begin
      used_in = used_ff;
      if (pick_ctl.clear) begin
         used_in = '0;
      end else if (pick_ctl.mark) begin
         // Colors outside one to NUM_COLORS never block a choice.
         for (int i = 0; i < NUM_COLORS; i++) begin
            if (32'(pick_ctl.color) == i + 1) begin
               used_in[i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      used_ff <= used_in;
   end

   assign free_color = first_free(used_ff);

endmodule

[rtl/gcol_check.sv]
// ---------------------------------------------------------------------------
// Greedy graph coloring port checker
// Watches the request and response words on the top-level ports.
// ---------------------------------------------------------------------------
`include "greedy_graph_coloring_assert.svh"

module gcol_check
   import gcol_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [ACTION_W-1:0] req_action,
   input logic [VERTEX_W-1:0] req_vertex,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COLOR_W-1:0]  rsp_color,
   input logic [COLOR_W-1:0]  rsp_max_color
);

   logic                 color_start;
   logic                 color_ok;
   logic                 rsp_stall;
   logic [2*COLOR_W-1:0] rsp_word;

   assign color_start = req_valid && req_ready && (req_action == ACT_COLOR)
                        && vertex_ok(req_vertex);
   assign color_ok    = (rsp_color != '0) && (rsp_color <= rsp_max_color);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_color, rsp_max_color};

   // The table sweep after reset keeps the block busy and silent.
   `GCOL_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !req_ready && !rsp_valid)

   // A color request occupies the engine for at least the degree read.
   `GCOL_ASSERT_NEXT(a_color_busy, clock, reset, color_start, !req_ready)

   // The chosen color is positive and never above the running maximum.
   `GCOL_ASSERT_IMPL(a_color_le_max, clock, reset, rsp_valid, color_ok)

   // A stalled response word holds its contents.
   `GCOL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind greedy_graph_coloring gcol_check u_gcol_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_action    (req_ch.action),
   .req_vertex    (req_ch.vertex),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_color     (rsp_ch.color),
   .rsp_max_color (rsp_ch.max_color)
);
